/* rtl/mrd_pkg.sv */
package mrd_pkg;

  localparam int MaxFrame = 256;
  localparam int CntW     = $clog2(MaxFrame + 1);
  localparam int LenW     = CntW + 1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FuncReadHold    = 8'h03;
  localparam logic [7:0] FuncWriteSingle = 8'h06;
  localparam logic [7:0] FuncWriteMulti  = 8'h10;

  localparam logic [CntW-1:0] FixedLen  = CntW'(8);
  localparam logic [CntW-1:0] QtyIndex  = CntW'(6);
  localparam logic [LenW-1:0] MultiBase = LenW'(9);

  localparam logic       KindData  = 1'b0;
  localparam logic       KindAbort = 1'b1;

  localparam logic [1:0] StatNone    = 2'd0;
  localparam logic [1:0] StatOk      = 2'd1;
  localparam logic [1:0] StatCrcErr  = 2'd2;
  localparam logic [1:0] StatAddrErr = 2'd3;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic [7:0] byte_index;
    logic       byte_stored;
    logic       frame_end;
    logic [1:0] frame_status;
    logic [7:0] func_code;
    logic       dropped;
    logic       receiving;
  } mrd_result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mrd_in_stage.sv */
module mrd_in_stage import mrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic       kind_i,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic       kind_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic       kind_q;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      kind_q <= kind_i;
      byte_q <= byte_i;
    end
  end

endmodule

/* rtl/mrd_frame_core.sv */
module mrd_frame_core import mrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        fire_i,
  input  logic        kind_i,
  input  logic [7:0]  byte_i,
  output mrd_result_t result_o
);

  logic [7:0]      dev_id_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      func_q, func_d;
  logic [7:0]      addr_q, addr_d;

  logic [CntW-1:0] idx;
  logic [LenW-1:0] multi_len;
  logic            stored;
  logic            drop;

  always_comb begin
    result_o  = '0;
    cnt_d     = cnt_q;
    len_d     = len_q;
    crc_d     = crc_q;
    func_d    = func_q;
    addr_d    = addr_q;
    idx       = '0;
    multi_len = '0;
    stored    = 1'b0;
    drop      = 1'b0;
    if (kind_i == KindAbort) begin
      result_o.func_code = func_q;
      drop   = (cnt_q != '0);
      cnt_d  = '0;
      len_d  = '0;
      crc_d  = CrcInit;
      func_d = '0;
      addr_d = '0;
    end else begin
      // frame overflow, start over with this byte
      if (cnt_q >= CntW'(MaxFrame)) begin
        cnt_d  = '0;
        len_d  = '0;
        crc_d  = CrcInit;
        func_d = '0;
        addr_d = '0;
        drop   = 1'b1;
      end
      idx = cnt_d;
      if (idx == CntW'(0)) begin
        addr_d = byte_i;
      end
      if (idx == CntW'(1)) begin
        func_d = byte_i;
      end
      crc_d  = crc_byte(crc_d, byte_i);
      cnt_d  = idx + CntW'(1);
      stored = 1'b1;
      result_o.echo_byte  = byte_i;
      result_o.byte_index = idx[7:0];
      result_o.func_code  = func_d;
      multi_len = MultiBase + LenW'(byte_i);

      if (cnt_d >= CntW'(2)) begin
        if (func_d == FuncReadHold || func_d == FuncWriteSingle) begin
          len_d = FixedLen;
        end else if (func_d == FuncWriteMulti) begin
          if (idx == QtyIndex) begin
            if (multi_len > LenW'(MaxFrame)) begin
              cnt_d  = '0;
              len_d  = '0;
              crc_d  = CrcInit;
              func_d = '0;
              addr_d = '0;
              stored = 1'b0;
              drop   = 1'b1;
            end else begin
              len_d = multi_len[CntW-1:0];
            end
          end
        end else if (cnt_d >= FixedLen) begin
          len_d = FixedLen;
        end
      end

      if (stored && len_d != '0 && cnt_d >= len_d) begin
        result_o.frame_end = 1'b1;
        if (crc_d != 16'h0000) begin
          result_o.frame_status = StatCrcErr;
        end else if (addr_d != dev_id_q) begin
          result_o.frame_status = StatAddrErr;
        end else begin
          result_o.frame_status = StatOk;
        end
        cnt_d  = '0;
        len_d  = '0;
        crc_d  = CrcInit;
        func_d = '0;
        addr_d = '0;
      end
    end
    result_o.byte_stored = stored;
    result_o.dropped     = drop;
    result_o.receiving   = (cnt_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= 8'd1;
      cnt_q    <= '0;
      len_q    <= '0;
      crc_q    <= CrcInit;
      func_q   <= '0;
      addr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        dev_id_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        cnt_q  <= cnt_d;
        len_q  <= len_d;
        crc_q  <= crc_d;
        func_q <= func_d;
        addr_q <= addr_d;
      end
    end
  end

endmodule

/* rtl/mrd_out_stage.sv */
module mrd_out_stage import mrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  mrd_result_t result_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output mrd_result_t result_o
);

  logic        valid_q;
  mrd_result_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

/* rtl/modbus_rtu_request_deframer_top.sv */
// Modbus RTU request deframer with CRC-16/MODBUS check.
// Slave stream: one request per item, tdata carries the received byte and
// tuser[0] the kind (0 data byte, 1 abort of a partial frame on a gap).
// Master stream: one result per request. tlast marks the byte that completed
// a frame; tdata carries echo byte, byte index, stored flag, frame status
// (1 accepted, 2 crc error, 3 other address), function code, dropped and
// receiving flags.
// cfg_we_i/cfg_wdata_i write the own slave address; write it only while idle.
// A request is held in the input register and its result in the output register.
// Throughput: one request per cycle unless the receiver stalls; the frame state
// (byte count, length and an unrolled 8-bit crc step) is updated per request.
// Reset clears the frame state, sets the slave address to 1 and empties both
// register stages. When the receiver stalls, the result register holds and
// the input register still takes one more request before tready drops.
module modbus_rtu_request_deframer_top import mrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i,  // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] echo_byte, [15:8] byte_index, [16] byte_stored, [18:17] frame_status,
  // [26:19] func_code, [27] dropped, [28] receiving, [31:29] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic        in_valid;
  logic        in_kind;
  logic [7:0]  in_byte;
  logic        out_free;
  logic        take;
  mrd_result_t core_res;
  mrd_result_t out_res;

  assign take = in_valid && out_free;

  mrd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .kind_i  (s_axis_tuser_i[0]),
    .byte_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .take_i  (take),
    .kind_o  (in_kind),
    .byte_o  (in_byte)
  );

  mrd_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (take),
    .kind_i      (in_kind),
    .byte_i      (in_byte),
    .result_o    (core_res)
  );

  mrd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .result_i (core_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {3'b000, out_res.receiving, out_res.dropped, out_res.func_code,
                           out_res.frame_status, out_res.byte_stored, out_res.byte_index,
                           out_res.echo_byte};
  assign m_axis_tlast_o = out_res.frame_end;

endmodule

/* rtl/mrd_checker.sv */
module mrd_checker import mrd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // completed frame always carries a status and leaves nothing held
  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o[18:17] != StatNone && m_axis_tdata_o[16] && !m_axis_tdata_o[28])
    else $error("frame end without status or with frame still held");

  // status only on the completing byte
  a_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[18:17] == StatNone)
    else $error("status reported outside frame end");

  // a drop that keeps no byte leaves no partial frame
  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[27] && !m_axis_tdata_o[16] |-> !m_axis_tdata_o[28])
    else $error("partial frame held after drop");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

endmodule

bind modbus_rtu_request_deframer_top mrd_checker u_mrd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
